// ===== rtl/eegp2_pkg.sv =====
// Shared types and constants for the P2 packet encoder.
// Holds packet byte codes, field widths and the byte-level helper.
// No dependencies; compiled first.
package eegp2_pkg;

  // field widths
  localparam int SAMPLE_W = 8;
  localparam int CHAN_W   = 24;
  localparam int CODE_W   = 10;
  localparam int NUM_CH   = 6;
  localparam int PKT_BYTES = 17;
  localparam int IDX_W    = 5;

  // fixed packet bytes
  localparam logic [7:0] SYNC_FIRST      = 8'hA5;
  localparam logic [7:0] SYNC_SECOND     = 8'h5A;
  localparam logic [7:0] PACKET_VERSION  = 8'h02;
  localparam logic [7:0] SYNC_SUBSTITUTE = 8'hA4;
  localparam logic [7:0] SWITCHES_LOW    = 8'h07;
  localparam logic [7:0] SWITCHES_HIGH   = 8'h0F;

  // byte positions within a packet
  localparam logic [IDX_W-1:0] IDX_SYNC_A   = 5'd0;
  localparam logic [IDX_W-1:0] IDX_SYNC_B   = 5'd1;
  localparam logic [IDX_W-1:0] IDX_VERSION  = 5'd2;
  localparam logic [IDX_W-1:0] IDX_SAMPLE   = 5'd3;
  localparam logic [IDX_W-1:0] IDX_CH_FIRST = 5'd4;
  localparam logic [IDX_W-1:0] IDX_CH_LAST  = 5'd15;
  localparam logic [IDX_W-1:0] IDX_SWITCH   = 5'd16;

  // switch byte phase counter
  localparam int PHASE_W = 5;
  localparam logic [PHASE_W-1:0] PHASE_HALF = 5'd9;
  localparam logic [PHASE_W-1:0] PHASE_LAST = 5'd17;

  // test ramp: v = (8950 * t) / 255 + 639, divide done as multiply by reciprocal
  localparam logic [13:0] RAMP_AMPLITUDE = 14'd8950;
  localparam logic [8:0]  RAMP_CENTER    = 9'd127;
  localparam logic signed [13:0] RAMP_OFFSET = 14'sd639;
  localparam logic [21:0] RAMP_RECIP     = 22'd2105377;  // ceil(2^29 / 255)
  localparam int          RAMP_SHIFT     = 29;

  // cycles from captured sample to valid lane code
  localparam logic [1:0] LANE_LAT = 2'd3;

  typedef logic [CODE_W-1:0] code_t;

  // one packet's worth of data handed to the serializer
  typedef struct packed {
    logic [SAMPLE_W-1:0]     sample;
    code_t [NUM_CH-1:0]      codes;
  } eegp2_pkt_t;

  // a data byte must never look like the first sync byte
  function automatic logic [7:0] unsync(input logic [7:0] b);
    unsync = (b == SYNC_FIRST) ? SYNC_SUBSTITUTE : b;
  endfunction

endpackage

// ===== rtl/eegp2_if.sv =====
// Valid/ready channel interfaces for the P2 packet encoder.
// eegp2_in_if carries one sample set, eegp2_out_if one packet byte.
// Depends on eegp2_pkg.
interface eegp2_in_if import eegp2_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [SAMPLE_W-1:0]      sample_number;
  logic signed [CHAN_W-1:0] channel_0;
  logic signed [CHAN_W-1:0] channel_1;
  logic signed [CHAN_W-1:0] channel_2;
  logic signed [CHAN_W-1:0] channel_3;
  logic signed [CHAN_W-1:0] channel_4;
  logic signed [CHAN_W-1:0] channel_5;

  modport source (output valid, sample_number, channel_0, channel_1, channel_2,
                  channel_3, channel_4, channel_5, input ready);
  modport sink (input valid, sample_number, channel_0, channel_1, channel_2,
                channel_3, channel_4, channel_5, output ready);
endinterface

interface eegp2_out_if import eegp2_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

// ===== rtl/eegp2_lane.sv =====
// One channel lane: builds the test ramp and encodes a sample to a 10-bit code.
// Three register stages (ramp scale, reciprocal divide, encode).
// Depends on eegp2_pkg.
module eegp2_lane import eegp2_pkg::*; (
  input  logic                     clk,
  input  logic [SAMPLE_W-1:0]      sample,
  input  logic [2:0]               chan_mult,
  input  logic                     synth,
  input  logic signed [CHAN_W-1:0] chan,
  output code_t                    code
);

  // stage 1: t = (s * (c+1)) mod 256 - 127, then |t| * 8950
  logic [7:0]        prod_lo;
  logic signed [8:0] t_s;
  logic              t_neg;
  logic [7:0]        t_mag;
  logic [20:0]       m1_r;
  logic              neg1_r;

  assign prod_lo = 8'(11'(sample) * 11'(chan_mult));
  assign t_s     = $signed({1'b0, prod_lo}) - $signed(RAMP_CENTER);
  assign t_neg   = t_s[8];
  assign t_mag   = t_neg ? 8'(-t_s) : t_s[7:0];

  always_ff @(posedge clk) begin
    m1_r   <= 21'(22'(t_mag) * 22'(RAMP_AMPLITUDE));
    neg1_r <= t_neg;
  end

  // stage 2: divide by 255 via reciprocal multiply (exact for this range)
  logic [42:0] recip_prod;
  logic [12:0] q2_r;
  logic        neg2_r;

  assign recip_prod = 43'(m1_r) * 43'(RAMP_RECIP);

  always_ff @(posedge clk) begin
    q2_r   <= recip_prod[RAMP_SHIFT+12:RAMP_SHIFT];
    neg2_r <= neg1_r;
  end

  // stage 3: restore sign, add offset, pick source, divide by 32 and clamp
  logic signed [13:0]       q_s;
  logic signed [13:0]       ramp;
  logic signed [CHAN_W-1:0] v;
  code_t                    code_nxt;
  code_t                    code_r;

  assign q_s  = $signed({1'b0, q2_r});
  assign ramp = (neg2_r ? -q_s : q_s) + RAMP_OFFSET;
  assign v    = synth ? {{(CHAN_W-14){ramp[13]}}, ramp} : chan;

  always_comb begin
    if (v[CHAN_W-1]) begin
      // negative: quotient truncates to zero only for -31..-1
      if ((&v[CHAN_W-2:5]) && (v[4:0] != 5'd0)) code_nxt = '0;
      else                                       code_nxt = '1;
    end else if (v[CHAN_W-2:15] != '0) begin
      code_nxt = '1;
    end else begin
      code_nxt = v[14:5];
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  assign code = code_r;

endmodule

// ===== rtl/eegp2_serializer.sv =====
// Merge stage: combines the lane codes into a 17-byte packet, one word per beat.
// Holds the output register and the switch-byte phase counter.
// Depends on eegp2_pkg.
module eegp2_serializer import eegp2_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load_valid,
  output logic       load_ready,
  input  eegp2_pkt_t load_pkt,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic               busy_r;
  logic [IDX_W-1:0]   idx_r;
  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic               out_last_r;
  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  eegp2_pkt_t         pkt_r;
  logic               sw_high_r;
  logic               adv;
  logic               load_go;
  logic [IDX_W-1:0]   ch_off;
  logic [2:0]         ch_sel;
  code_t              ch_code;
  logic [7:0]         cur_byte;

  // move a word into the output register when it is empty or being taken
  assign adv        = busy_r && (!out_valid_r || out_ready);
  assign load_ready = !busy_r || (adv && (idx_r == IDX_SWITCH));
  assign load_go    = load_valid && load_ready;
  assign phase_nxt  = (phase_r == PHASE_LAST) ? '0 : phase_r + 1'b1;

  // byte select for the current position
  assign ch_off  = idx_r - IDX_CH_FIRST;
  assign ch_sel  = ch_off[3:1];
  assign ch_code = pkt_r.codes[ch_sel];

  always_comb begin
    case (idx_r)
      IDX_SYNC_A:  cur_byte = SYNC_FIRST;
      IDX_SYNC_B:  cur_byte = SYNC_SECOND;
      IDX_VERSION: cur_byte = PACKET_VERSION;
      IDX_SAMPLE:  cur_byte = unsync(pkt_r.sample);
      IDX_SWITCH:  cur_byte = sw_high_r ? SWITCHES_HIGH : SWITCHES_LOW;
      default: begin
        if (idx_r inside {[IDX_CH_FIRST:IDX_CH_LAST]}) begin
          // high byte first, then low byte
          if (ch_off[0]) cur_byte = unsync(ch_code[7:0]);
          else           cur_byte = unsync({6'd0, ch_code[CODE_W-1:8]});
        end else begin
          cur_byte = '0;
        end
      end
    endcase
  end

  // control state; a load restarts the packet at the sync bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load_go) begin
        busy_r  <= 1'b1;
        idx_r   <= '0;
        phase_r <= phase_nxt;
      end else if (adv) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == IDX_SWITCH) busy_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= cur_byte;
      out_last_r <= (idx_r == IDX_SWITCH);
    end
    if (load_go) begin
      pkt_r     <= load_pkt;
      sw_high_r <= (phase_r >= PHASE_HALF);
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // checks
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= IDX_SWITCH))
    else $error("packet index past switch byte");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PHASE_LAST)
    else $error("switch phase out of range");

  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    load_go |=> (busy_r && (idx_r == IDX_SYNC_A)))
    else $error("load did not restart packet");

  a_last_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> ((out_byte_r == SWITCHES_LOW) ||
                                      (out_byte_r == SWITCHES_HIGH)))
    else $error("last flag on a non-switch byte");

endmodule

// ===== rtl/eeg_p2_packet_encoder_unit.sv =====
// P2 packet encoder top level: capture register, six lanes and the serializer.
// Depends on eegp2_pkg, eegp2_if, eegp2_lane and eegp2_serializer.
//
// Usage:
//   in_ch  (sink)  : one sample set per word (sample_number, channel_0..5).
//   out_ch (source): one packet byte per word; last marks the switch byte.
//   cfg_we/cfg_data: writes use_synthetic; write only while the block is idle.
// Each accepted sample set yields 17 words: A5 5A 02, sample byte, two bytes
// per channel (high first), switch byte.
// The first byte of a packet passes the capture register, the three lane stages,
// the serializer load and its output register.
// With an unstalled receiver, packets can go out back to back, paced by the
// single byte-wide output register; the next sample set is captured and
// encoded while the current packet is still going out.
// Receiver stall: the output word holds and the packet pauses. in_ch.ready is
// low while a set sits in the capture register, at least until its lane codes
// settle; under a stall it stays low until the serializer takes the waiting set.
// Reset: synchronous, active low; clears use_synthetic, the switch phase and
// all valid state.
module eeg_p2_packet_encoder_unit import eegp2_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  eegp2_in_if.sink    in_ch,
  eegp2_out_if.source out_ch,
  input  logic cfg_we,
  input  logic cfg_data
);

  logic                     synth_r;
  logic                     cap_vld_r;
  logic [1:0]               wait_r;
  logic [SAMPLE_W-1:0]      sample_r;
  logic signed [CHAN_W-1:0] chan_r [NUM_CH];
  logic                     in_fire;
  logic                     load_valid;
  logic                     load_ready;
  eegp2_pkt_t               load_pkt;
  code_t                    codes [NUM_CH];

  assign in_ch.ready = !cap_vld_r;
  assign in_fire     = in_ch.valid && !cap_vld_r;
  assign load_valid  = cap_vld_r && (wait_r == '0);

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n)      synth_r <= 1'b0;
    else if (cfg_we) synth_r <= cfg_data;
  end

  // capture control: hold the set until lanes settle and the serializer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_vld_r <= 1'b0;
      wait_r    <= '0;
    end else begin
      if (wait_r != '0) wait_r <= wait_r - 1'b1;
      if (in_fire) begin
        cap_vld_r <= 1'b1;
        wait_r    <= LANE_LAT;
      end else if (load_valid && load_ready) begin
        cap_vld_r <= 1'b0;
      end
    end
  end

  // capture payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r  <= in_ch.sample_number;
      chan_r[0] <= in_ch.channel_0;
      chan_r[1] <= in_ch.channel_1;
      chan_r[2] <= in_ch.channel_2;
      chan_r[3] <= in_ch.channel_3;
      chan_r[4] <= in_ch.channel_4;
      chan_r[5] <= in_ch.channel_5;
    end
  end

  // channel lanes
  for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
    eegp2_lane u_lane (
      .clk       (clk),
      .sample    (sample_r),
      .chan_mult (3'(i + 1)),
      .synth     (synth_r),
      .chan      (chan_r[i]),
      .code      (codes[i])
    );
    assign load_pkt.codes[i] = codes[i];
  end

  assign load_pkt.sample = sample_r;

  // merge into packet bytes
  eegp2_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (load_valid),
    .load_ready (load_ready),
    .load_pkt   (load_pkt),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .out_last   (out_ch.last)
  );

  // checks
  a_no_early_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (!load_valid && (wait_r == LANE_LAT)))
    else $error("lane codes used before they settle");

  a_hold_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_vld_r && !(load_valid && load_ready)) |=> (cap_vld_r && $stable(sample_r)))
    else $error("captured sample changed before load");

  a_wait_only_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (wait_r != '0) |-> cap_vld_r)
    else $error("lane wait running with no captured set");

endmodule
